@@ hdl/lsp_pkg.sv @@
// ----------------------------------------------------------------------------
// lsp_pkg
// Shared types and constants of the lottery slot picker.
// ----------------------------------------------------------------------------
package lsp_pkg;

  localparam int SLOTS_DEF   = 64;
  localparam int SLOT_W      = 6;
  localparam int TICKET_W    = 10;
  localparam int RND_W       = 32;
  localparam int MAX_TICKETS = 1023;
  localparam int OUT_W       = 16;

  localparam int S_DATA_W = 56;
  localparam int M_DATA_W = 40;

  localparam logic OP_UPDATE = 1'b0;
  localparam logic OP_DRAW   = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SUM,
    ST_DIV,
    ST_WALK,
    ST_DONE
  } lsp_state_e;

endpackage

@@ hdl/lsp_mod.sv @@
// ----------------------------------------------------------------------------
// lsp_mod
// Restoring remainder unit: one dividend bit per cycle.
// ----------------------------------------------------------------------------
module lsp_mod #(
  parameter int TOT_W = 16
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [lsp_pkg::RND_W-1:0] dividend_i,
  input  logic [TOT_W:0]            divisor_i,
  output logic                      done_o,
  output logic [TOT_W-1:0]          rem_o
);
  import lsp_pkg::*;

  localparam int CNT_W = $clog2(RND_W);

  logic             busy_q;
  logic             done_q;
  logic [CNT_W-1:0] cnt_q;
  logic [RND_W-1:0] dvd_q;
  logic [TOT_W:0]   div_q;
  logic [TOT_W-1:0] rem_q;
  logic [TOT_W:0]   trial;
  logic [TOT_W:0]   diff;

  assign trial = {rem_q, dvd_q[RND_W-1]};
  assign diff  = trial - div_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + CNT_W'(1);
        if (cnt_q == CNT_W'(RND_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q <= dividend_i;
      div_q <= divisor_i;
      rem_q <= '0;
    end else if (busy_q) begin
      dvd_q <= {dvd_q[RND_W-2:0], 1'b0};
      if (trial >= div_q) begin
        rem_q <= diff[TOT_W-1:0];
      end else begin
        rem_q <= trial[TOT_W-1:0];
      end
    end
  end

  assign done_o = done_q;
  assign rem_o  = rem_q;

endmodule

@@ hdl/lottery_slot_picker.sv @@
// ----------------------------------------------------------------------------
// lottery_slot_picker
// Lottery slot table: update writes one slot, draw picks a winner, marks it not runnable.
// ----------------------------------------------------------------------------
// An update word gives an all-zero result word. For a draw word, the first pass
// over the slot table memory totals the runnable tickets. The bit-serial
// remainder unit then reduces the random word to a winning ticket. A second
// pass stops at the winner, and then the output register is loaded. The single
// read port of the table sets the two passes. The input is not ready while a
// word is in work. The result sits in an output register until taken, and the
// input is ready again as soon as that register is loaded. The table comes out
// of reset empty, with no clearing pass.
module lottery_slot_picker #(
  parameter int SLOTS = lsp_pkg::SLOTS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  // slot[5:0], runnable[6], tickets[16:7], random_word[48:17], zero fill
  input  logic [lsp_pkg::S_DATA_W-1:0] s_axis_tdata,
  // op
  input  logic                         s_axis_tuser,
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  // chosen_slot[5:0], ticket_total[21:6], winning_ticket[37:22], zero fill
  output logic [lsp_pkg::M_DATA_W-1:0] m_axis_tdata,
  // chosen_valid
  output logic                         m_axis_tuser
);
  import lsp_pkg::*;

  localparam int IDX_W = $clog2(SLOTS);
  localparam int CNT_W = $clog2(SLOTS + 1);
  localparam int TOT_W = $clog2(SLOTS * MAX_TICKETS + 1);
  localparam int EXT_W = TOT_W + OUT_W;
  localparam int ENT_W = TICKET_W + 1;

  lsp_state_e state_q, state_d;

  logic [ENT_W-1:0] mem [SLOTS];
  logic [SLOTS-1:0] valid_q;

  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [TOT_W-1:0] total_q, total_d;
  logic [TOT_W-1:0] sum_q, sum_d;
  logic [TOT_W-1:0] win_q, win_d;
  logic [RND_W-1:0] rnd_q, rnd_d;

  logic              res_vld_q, res_vld_d;
  logic [SLOT_W-1:0] res_slot_q, res_slot_d;

  logic              rd_vld_q;
  logic [IDX_W-1:0]  rd_idx_q;
  logic              rd_ok_q;
  logic [ENT_W-1:0]  rdata_q;

  logic                m_tvalid_q;
  logic [M_DATA_W-1:0] m_tdata_q;
  logic                m_tuser_q;
  logic                out_load;

  logic              issue;
  logic [IDX_W-1:0]  rd_addr;
  logic              mem_we;
  logic [IDX_W-1:0]  mem_waddr;
  logic [ENT_W-1:0]  mem_wdata;
  logic              div_start;
  logic              div_done;
  logic [TOT_W-1:0]  div_rem;

  logic              accept;
  logic [SLOT_W-1:0]       in_slot;
  logic                    in_run;
  logic [TICKET_W-1:0]     in_tix;
  logic [RND_W-1:0]        in_rnd;
  logic [IDX_W+SLOT_W-1:0] in_slot_ext;
  logic [IDX_W+SLOT_W-1:0] who_ext;
  logic                    in_range;

  logic                ent_run;
  logic [TICKET_W-1:0] ent_tix;
  logic [TOT_W-1:0]    walk_sum;

  logic [EXT_W-1:0]  total_ext;
  logic [EXT_W-1:0]  win_ext;
  logic [OUT_W-1:0]  total_sat;
  logic [OUT_W-1:0]  win_sat;

  assign in_slot = s_axis_tdata[5:0];
  assign in_run  = s_axis_tdata[6];
  assign in_tix  = s_axis_tdata[16:7];
  assign in_rnd  = s_axis_tdata[48:17];

  assign in_slot_ext = {{IDX_W{1'b0}}, in_slot};
  assign in_range    = (int'(in_slot) < SLOTS);
  assign who_ext     = {{SLOT_W{1'b0}}, rd_idx_q};

  assign s_axis_tready = (state_q == ST_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;

  assign issue   = ((state_q == ST_SUM) || (state_q == ST_WALK)) && (cnt_q < CNT_W'(SLOTS));
  assign rd_addr = cnt_q[IDX_W-1:0];

  assign ent_run  = rd_ok_q & rdata_q[TICKET_W];
  assign ent_tix  = rd_ok_q ? rdata_q[TICKET_W-1:0] : '0;
  assign walk_sum = sum_q + TOT_W'(ent_tix);

  assign total_ext = EXT_W'(total_q);
  assign win_ext   = EXT_W'(win_q);
  assign total_sat = (total_ext > EXT_W'(16'hFFFF)) ? 16'hFFFF : total_ext[OUT_W-1:0];
  assign win_sat   = (win_ext > EXT_W'(16'hFFFF)) ? 16'hFFFF : win_ext[OUT_W-1:0];

  lsp_mod #(
    .TOT_W(TOT_W)
  ) u_mod (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (rnd_q),
    .divisor_i  ((TOT_W + 1)'(total_q) + (TOT_W + 1)'(1)),
    .done_o     (div_done),
    .rem_o      (div_rem)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    total_d    = total_q;
    sum_d      = sum_q;
    win_d      = win_q;
    rnd_d      = rnd_q;
    res_vld_d  = res_vld_q;
    res_slot_d = res_slot_q;
    mem_we     = 1'b0;
    mem_waddr  = in_slot_ext[IDX_W-1:0];
    mem_wdata  = {in_run, in_tix};
    div_start  = 1'b0;
    out_load   = 1'b0;
    if (issue) begin
      cnt_d = cnt_q + CNT_W'(1);
    end
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          res_vld_d  = 1'b0;
          res_slot_d = '0;
          total_d    = '0;
          win_d      = '0;
          cnt_d      = '0;
          if (s_axis_tuser == OP_DRAW) begin
            rnd_d   = in_rnd;
            state_d = ST_SUM;
          end else begin
            mem_we  = in_range;
            state_d = ST_DONE;
          end
        end
      end
      ST_SUM: begin
        if (rd_vld_q && ent_run) begin
          total_d = total_q + TOT_W'(ent_tix);
        end
        if (!issue && !rd_vld_q) begin
          div_start = 1'b1;
          state_d   = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          win_d   = div_rem;
          sum_d   = '0;
          cnt_d   = '0;
          state_d = ST_WALK;
        end
      end
      ST_WALK: begin
        if (rd_vld_q && ent_run) begin
          if (walk_sum < win_q) begin
            sum_d = walk_sum;
          end else begin
            res_vld_d  = 1'b1;
            res_slot_d = who_ext[SLOT_W-1:0];
            mem_we     = 1'b1;
            mem_waddr  = rd_idx_q;
            mem_wdata  = {1'b0, ent_tix};
            state_d    = ST_DONE;
          end
        end else if (!issue && !rd_vld_q) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!m_tvalid_q || m_axis_tready) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    cnt_q      <= cnt_d;
    total_q    <= total_d;
    sum_q      <= sum_d;
    win_q      <= win_d;
    rnd_q      <= rnd_d;
    res_vld_q  <= res_vld_d;
    res_slot_q <= res_slot_d;
    rd_idx_q   <= rd_addr;
    rdata_q    <= mem[rd_addr];
    rd_ok_q    <= valid_q[rd_addr];
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      rd_vld_q <= issue;
      if (mem_we) begin
        valid_q[mem_waddr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_tvalid_q <= 1'b0;
    end else if (out_load) begin
      m_tvalid_q <= 1'b1;
    end else if (m_axis_tready) begin
      m_tvalid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      m_tdata_q <= {2'b00, win_sat, total_sat, res_slot_q};
      m_tuser_q <= res_vld_q;
    end
  end

  assign m_axis_tvalid = m_tvalid_q;
  assign m_axis_tdata  = m_tdata_q;
  assign m_axis_tuser  = m_tuser_q;

endmodule

@@ hdl/lsp_checker.sv @@
// ----------------------------------------------------------------------------
// lsp_checker
// Port-level checks of the lottery slot picker, bound to the top level.
// ----------------------------------------------------------------------------
module lsp_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         s_axis_tvalid,
  input logic                         s_axis_tready,
  input logic [lsp_pkg::M_DATA_W-1:0] m_axis_tdata,
  input logic                         m_axis_tuser,
  input logic                         m_axis_tvalid,
  input logic                         m_axis_tready
);
  import lsp_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result word changed while stalled");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input ready right after an accepted word");

  a_win_in_total: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tdata[37:22] <= m_axis_tdata[21:6])
    else $error("winning ticket above ticket total");

  a_no_winner_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata == '0)
    else $error("result without winner carries nonzero fields");

endmodule

bind lottery_slot_picker lsp_checker u_lsp_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready)
);
